/* design/nvr_pkg.sv */
package nvr_pkg;

  // Default number of fractional bits in the unit quotient.
  localparam int FRAC_BITS_DEF = 24;

  // Code width, lane count and full-scale codes.
  localparam int CODE_W = 16;
  localparam int NUM_LANES = 3;
  localparam int SQ_W = 2 * CODE_W;
  // Sum of three squares of 16-bit magnitudes fits in 34 bits.
  localparam int SUM_W = SQ_W + 2;
  localparam logic [CODE_W-1:0] FULL_8 = 16'd255;
  localparam logic [CODE_W-1:0] FULL_16 = 16'hFFFF;

  // Control that travels with each pipeline beat.
  typedef struct packed {
    logic valid;
    logic wide;
  } ctl_t;

endpackage

/* design/nvr_root_step.sv */
module nvr_root_step
  import nvr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT = 0,
  localparam int RW = 2 * FRAC_BITS + SUM_W + 3,
  localparam int TW = FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl_in,
  input  logic [SUM_W-1:0]  s_in,
  input  logic [RW-1:0]     rem_in [NUM_LANES],
  input  logic [RW-1:0]     ts_in [NUM_LANES],
  input  logic [TW-1:0]     t_in [NUM_LANES],
  input  logic              neg_in [NUM_LANES],
  output ctl_t              ctl_out,
  output logic [SUM_W-1:0]  s_out,
  output logic [RW-1:0]     rem_out [NUM_LANES],
  output logic [RW-1:0]     ts_out [NUM_LANES],
  output logic [TW-1:0]     t_out [NUM_LANES],
  output logic              neg_out [NUM_LANES]
);

  logic [RW-1:0] term [NUM_LANES];
  logic          take [NUM_LANES];

  // Trying this bit adds (2*t*2^b + 2^2b)*S to t^2*S; accept it while the
  // remainder still covers that increment.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      term[i] = (ts_in[i] << (BIT + 1)) + (RW'(s_in) << (2 * BIT));
      take[i] = (term[i] <= rem_in[i]);
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    s_out <= s_in;
    for (int i = 0; i < NUM_LANES; i++) begin
      neg_out[i] <= neg_in[i];
      if (take[i]) begin
        rem_out[i] <= rem_in[i] - term[i];
        ts_out[i]  <= ts_in[i] + (RW'(s_in) << BIT);
        t_out[i]   <= t_in[i] | (TW'(1) << BIT);
      end else begin
        rem_out[i] <= rem_in[i];
        ts_out[i]  <= ts_in[i];
        t_out[i]   <= t_in[i];
      end
    end
  end

endmodule

/* design/normal_vector_renormalize_unit.sv */
// Channel   Handshake              Beat content
// pixel     start / busy           x_code, y_code, z_code
// result    done (one cycle)       x_out, y_out, z_out
// config    cfg_valid / cfg_ready  cfg_data (sample_format)
//
// One pixel is taken every cycle outside reset; each result passes through three
// front-end stages, then the square-root quotient, which resolves one bit per
// pipeline stage (FRAC_BITS + 1 stages), and then the encode stage.
// Reset clears all valid bits and the format register; busy is high during
// reset only. The receiver cannot stall, so the pipeline never holds.
module normal_vector_renormalize_unit
  import nvr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CODE_W-1:0] x_code,
  input  logic [CODE_W-1:0] y_code,
  input  logic [CODE_W-1:0] z_code,
  output logic              done,
  output logic [CODE_W-1:0] x_out,
  output logic [CODE_W-1:0] y_out,
  output logic [CODE_W-1:0] z_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int RW = 2 * FRAC_BITS + SUM_W + 3;
  localparam int TW = FRAC_BITS + 1;
  localparam int BW = FRAC_BITS + 2;
  localparam int PW = CODE_W + FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 2;
  localparam int LAT = FRAC_BITS + 5;

  logic              sample_format;
  logic              accept;
  logic [CODE_W-1:0] code_in [NUM_LANES];

  ctl_t              ctl_a;
  logic [CODE_W-1:0] mag_a [NUM_LANES];
  logic              neg_a [NUM_LANES];
  ctl_t              ctl_b;
  logic [SQ_W-1:0]   sq_b [NUM_LANES];
  logic              neg_b [NUM_LANES];

  ctl_t              ctl_p [NS];
  logic [SUM_W-1:0]  s_p [NS];
  logic [RW-1:0]     rem_p [NS][NUM_LANES];
  logic [RW-1:0]     ts_p [NS][NUM_LANES];
  logic [TW-1:0]     t_p [NS][NUM_LANES];
  logic              neg_p [NS][NUM_LANES];

  ctl_t              ctl_e;
  logic [CODE_W-1:0] n_e [NUM_LANES];

  assign accept = start && !busy;
  assign busy = rst;
  assign cfg_ready = 1'b1;
  assign code_in[0] = x_code;
  assign code_in[1] = y_code;
  assign code_in[2] = z_code;

  // Format register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sample_format <= cfg_data;
    end
  end

  // Front-end control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_p[0] <= '0;
    end else begin
      ctl_a <= '{valid: accept, wide: sample_format};
      ctl_b <= ctl_a;
      ctl_p[0] <= ctl_b;
    end
  end

  // Stage A: clamp each code and decode c = 2p - M into sign and magnitude.
  always_ff @(posedge clk) begin
    logic [CODE_W-1:0] full;
    logic [CODE_W-1:0] p;
    logic [CODE_W:0]   twice;
    full = sample_format ? FULL_16 : FULL_8;
    for (int i = 0; i < NUM_LANES; i++) begin
      p = (code_in[i] > full) ? full : code_in[i];
      twice = {p, 1'b0};
      neg_a[i] <= (twice < {1'b0, full});
      if (twice < {1'b0, full}) begin
        mag_a[i] <= CODE_W'({1'b0, full} - twice);
      end else begin
        mag_a[i] <= CODE_W'(twice - {1'b0, full});
      end
    end
  end

  // Stage B: square each magnitude.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      sq_b[i]  <= mag_a[i] * mag_a[i];
      neg_b[i] <= neg_a[i];
    end
  end

  // Stage C: squared length, and the scaled target mag^2 * 2^(2F).
  always_ff @(posedge clk) begin
    s_p[0] <= SUM_W'(sq_b[0]) + SUM_W'(sq_b[1]) + SUM_W'(sq_b[2]);
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_p[0][i] <= RW'(sq_b[i]) << (2 * FRAC_BITS);
      ts_p[0][i]  <= '0;
      t_p[0][i]   <= '0;
      neg_p[0][i] <= neg_b[i];
    end
  end

  // Quotient stages, most significant bit first.
  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_step
    nvr_root_step #(
      .FRAC_BITS(FRAC_BITS),
      .BIT(FRAC_BITS - k)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_p[k]),
      .s_in   (s_p[k]),
      .rem_in (rem_p[k]),
      .ts_in  (ts_p[k]),
      .t_in   (t_p[k]),
      .neg_in (neg_p[k]),
      .ctl_out(ctl_p[k+1]),
      .s_out  (s_p[k+1]),
      .rem_out(rem_p[k+1]),
      .ts_out (ts_p[k+1]),
      .t_out  (t_p[k+1]),
      .neg_out(neg_p[k+1])
    );
  end

  // Output control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e <= '0;
    end else begin
      ctl_e <= ctl_p[NS-1];
    end
  end

  // Encode stage: n = (M * (1 +/- u) + 1) / 2, clamped to full scale.
  always_ff @(posedge clk) begin
    logic [CODE_W-1:0] full;
    logic [TW-1:0]     t;
    logic [BW-1:0]     base;
    logic [PW-1:0]     prod;
    logic [CODE_W:0]   n;
    full = ctl_p[NS-1].wide ? FULL_16 : FULL_8;
    for (int i = 0; i < NUM_LANES; i++) begin
      t = (t_p[NS-1][i] > (TW'(1) << FRAC_BITS)) ? (TW'(1) << FRAC_BITS) : t_p[NS-1][i];
      if (neg_p[NS-1][i]) begin
        base = (BW'(1) << FRAC_BITS) - BW'(t);
      end else begin
        base = (BW'(1) << FRAC_BITS) + BW'(t);
      end
      prod = PW'(full) * PW'(base) + (PW'(1) << FRAC_BITS);
      n = (CODE_W + 1)'(prod >> (FRAC_BITS + 1));
      n_e[i] <= (n > {1'b0, full}) ? full : n[CODE_W-1:0];
    end
  end

  assign done = ctl_e.valid;
  assign x_out = n_e[0];
  assign y_out = n_e[1];
  assign z_out = n_e[2];

`ifndef SYNTHESIS
  // Every result strobe matches an earlier start beat.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching start beat");

  // A start beat always yields a result strobe.
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("start beat lost in the pipeline");

  // In 8-bit mode no output code exceeds 255.
  a_narrow_range: assert property (@(posedge clk) disable iff (rst)
    (done && !ctl_e.wide) |-> (x_out <= FULL_8 && y_out <= FULL_8 && z_out <= FULL_8))
    else $error("8-bit result above full scale");
`endif

endmodule

/* tb/testbench.sv */
module testbench
  import nvr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = FRAC + 5;
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CODE_W-1:0] x_code = '0;
  logic [CODE_W-1:0] y_code = '0;
  logic [CODE_W-1:0] z_code = '0;
  logic              done;
  logic [CODE_W-1:0] x_out;
  logic [CODE_W-1:0] y_out;
  logic [CODE_W-1:0] z_out;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  typedef struct {
    logic [CODE_W-1:0] x;
    logic [CODE_W-1:0] y;
    logic [CODE_W-1:0] z;
  } pixel_t;

  typedef struct {
    logic              wide;
    logic [CODE_W-1:0] x;
    logic [CODE_W-1:0] y;
    logic [CODE_W-1:0] z;
  } vector_row_t;

  pixel_t pending_normals[$];
  logic   fmt_wide = 1'b0;
  int     mismatches = 0;
  int     sender_idle_pct = 0;
  int     quiet_cycles = 0;

  normal_vector_renormalize_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .x_code   (x_code),
    .y_code   (y_code),
    .z_code   (z_code),
    .done     (done),
    .x_out    (x_out),
    .y_out    (y_out),
    .z_out    (z_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Largest t with t^2 * sumsq <= mag^2 * 2^(2*FRAC), capped at one.
  function automatic logic [63:0] unit_quotient(logic [63:0] mag, logic [63:0] sumsq);
    logic [127:0] bound;
    logic [127:0] trial_sq;
    logic [63:0]  t;
    logic [63:0]  cand;
    bound = {64'd0, mag * mag} << (2 * FRAC);
    t = '0;
    for (int b = FRAC; b >= 0; b--) begin
      cand = t | (64'd1 << b);
      trial_sq = {64'd0, cand} * {64'd0, cand} * {64'd0, sumsq};
      if (trial_sq <= bound) t = cand;
    end
    if (t > (64'd1 << FRAC)) t = 64'd1 << FRAC;
    return t;
  endfunction

  function automatic logic [CODE_W-1:0] encode_lane(longint c, logic [63:0] sumsq,
                                                   logic [63:0] full);
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] base;
    logic [63:0] n;
    one = 64'd1 << FRAC;
    t = unit_quotient((c < 0) ? -c : c, sumsq);
    base = (c < 0) ? one - t : one + t;
    n = (full * base + one) >> (FRAC + 1);
    if (n > full) n = full;
    return n[CODE_W-1:0];
  endfunction

  function automatic pixel_t renormalize(logic wide, pixel_t p);
    logic [63:0] full;
    logic [63:0] code[3];
    longint      c[3];
    logic [63:0] sumsq;
    logic [CODE_W-1:0] r[3];
    full = wide ? 64'd65535 : 64'd255;
    code[0] = p.x;
    code[1] = p.y;
    code[2] = p.z;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      if (code[i] > full) code[i] = full;
      c[i] = 2 * longint'(code[i]) - longint'(full);
      sumsq += c[i] * c[i];
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = (sumsq == 0) ? code[i][CODE_W-1:0] : encode_lane(c[i], sumsq, full);
    end
    return '{r[0], r[1], r[2]};
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  // Compare every result beat with the oldest outstanding normal.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
      end else begin
        want = pending_normals.pop_front();
        if (x_out !== want.x)
          report_mismatch($sformatf("x_out: got %0d, expected %0d", x_out, want.x));
        if (y_out !== want.y)
          report_mismatch($sformatf("y_out: got %0d, expected %0d", y_out, want.y));
        if (z_out !== want.z)
          report_mismatch($sformatf("z_out: got %0d, expected %0d", z_out, want.z));
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Sends one pixel; start stays high on return until the next decision.
  task automatic send_pixel(logic [CODE_W-1:0] x, logic [CODE_W-1:0] y,
                            logic [CODE_W-1:0] z);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    x_code <= x;
    y_code <= y;
    z_code <= z;
    do @(posedge clk); while (busy);
    pending_normals.insert(pending_normals.size(), renormalize(fmt_wide, '{x, y, z}));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  task automatic write_format(logic wide);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= wide;
    do @(posedge clk); while (!cfg_ready);
    fmt_wide = wide;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] random_code(logic wide);
    if (!wide && $urandom_range(1) == 0) return CODE_W'($urandom_range(255));
    return CODE_W'($urandom);
  endfunction

  vector_row_t directed[] = '{
    '{1'b0, 16'd0, 16'd0, 16'd0},
    '{1'b0, 16'd255, 16'd255, 16'd255},
    '{1'b0, 16'd255, 16'd0, 16'd0},
    '{1'b0, 16'd127, 16'd128, 16'd255},
    '{1'b0, 16'd128, 16'd127, 16'd127},
    '{1'b0, 16'd256, 16'd300, 16'd65535},
    '{1'b0, 16'hFFFF, 16'd0, 16'd128},
    '{1'b0, 16'd0, 16'd255, 16'd0},
    '{1'b0, 16'd127, 16'd127, 16'd127},
    '{1'b0, 16'h5555, 16'hAAAA, 16'd1},
    '{1'b1, 16'd0, 16'd0, 16'd0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{1'b1, 16'hFFFF, 16'd32767, 16'd32768},
    '{1'b1, 16'd32767, 16'd32768, 16'd32768},
    '{1'b1, 16'd32768, 16'd32767, 16'd32767},
    '{1'b1, 16'd0, 16'hFFFF, 16'd0},
    '{1'b1, 16'h5555, 16'hAAAA, 16'h00FF},
    '{1'b1, 16'd1, 16'd65534, 16'd32768},
    '{1'b1, 16'd256, 16'd300, 16'd255}
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, a format write whenever the row's format changes.
    write_format(1'b0);
    foreach (directed[i]) begin
      if (directed[i].wide != fmt_wide) write_format(directed[i].wide);
      send_pixel(directed[i].x, directed[i].y, directed[i].z);
    end

    // Random phases over both formats and several sender idle rates.
    for (int phase = 0; phase < 8; phase++) begin
      write_format(phase[0]);
      case (phase % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 79;
        2: sender_idle_pct = 24;
        default: sender_idle_pct = 50;
      endcase
      for (int n = 0; n < 50; n++) begin
        send_pixel(random_code(fmt_wide), random_code(fmt_wide), random_code(fmt_wide));
        // Once, in phase 2, hold off until the pipeline has emptied.
        if (n == 25 && phase == 2) drain();
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_normals.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_normals.size()));
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/nvr_pkg.sv
design/nvr_root_step.sv
design/normal_vector_renormalize_unit.sv
tb/testbench.sv
